[rtl/switched_io_sram_pattern_device_macros.svh]
// Assertion macros used by the checker file of the I/O pattern device.
// Depends on nothing; included by the checker module.
`ifndef SWITCHED_IO_SRAM_PATTERN_DEVICE_MACROS_SVH
`define SWITCHED_IO_SRAM_PATTERN_DEVICE_MACROS_SVH

// Implication checked in the next cycle, switched off while reset is held.
`define SIPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, also active during reset.
`define SIPD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sipd_pkg.sv]
// Types and constants of the I/O pattern device: port codes, state codes and
// the SRAM request bundle. Depends on nothing.
package sipd_pkg;

  // Width of the access address register.
  localparam int ADDR_W = 13;

  // Access types.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Sub-port codes.
  localparam logic [3:0] PORT_ID      = 4'd0;
  localparam logic [3:0] PORT_SWITCH  = 4'd1;
  localparam logic [3:0] PORT_COLOR   = 4'd3;
  localparam logic [3:0] PORT_PATTERN = 4'd4;
  localparam logic [3:0] PORT_ADDR_LO = 4'd7;
  localparam logic [3:0] PORT_ADDR_HI = 4'd8;
  localparam logic [3:0] PORT_SRAM    = 4'd9;

  // Fixed read values.
  localparam logic [7:0] ID_VALUE    = 8'hF7;
  localparam logic [7:0] SWITCH_ON   = 8'h7F;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] SRAM_RESET  = 8'hFF;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } sipd_state_t;

  // One SRAM access request.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } sipd_mem_req_t;

endpackage

[rtl/sipd_sram.sv]
// Byte-wide single-port SRAM with a registered read port.
// Depends on sipd_pkg for the request bundle.
module sipd_sram #(
  parameter int SRAM_BYTES = 2048
) (
  input  logic                   clk,
  input  sipd_pkg::sipd_mem_req_t mem_req,
  output logic [7:0]             mem_rdata
);
  import sipd_pkg::*;

  localparam int MEM_AW = $clog2(SRAM_BYTES);

  logic [7:0] mem [SRAM_BYTES];
  logic [7:0] rdata_r;

  // Write and registered read; the controller never issues both at once.
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.addr[MEM_AW-1:0]] <= mem_req.wdata;
    end
    if (mem_req.rd_en) begin
      rdata_r <= mem[mem_req.addr[MEM_AW-1:0]];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

[rtl/sipd_ctrl.sv]
// Access controller: decodes each bus transaction, holds the small registers,
// drives the SRAM, runs the clearing pass and owns the result register.
// Depends on sipd_pkg.
module sipd_ctrl #(
  parameter int SRAM_BYTES = 2048
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [3:0]              in_port_sel,
  input  logic [7:0]              in_write_data,
  input  logic                    in_front_switch,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_read_data,
  output logic                    out_fast_cpu,
  output sipd_pkg::sipd_mem_req_t mem_req,
  input  logic [7:0]              mem_rdata
);
  import sipd_pkg::*;

  localparam int MEM_AW = $clog2(SRAM_BYTES);
  localparam logic [ADDR_W:0] SRAM_LIM = (ADDR_W+1)'(SRAM_BYTES);
  localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(SRAM_BYTES - 1);

  sipd_state_t       state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [3:0]        col_lo_r, col_lo_nxt;
  logic [3:0]        col_hi_r, col_hi_nxt;
  logic [7:0]        pat_r, pat_nxt;
  logic              speed_r, speed_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_fast_r, out_fast_nxt;

  logic accept;
  logic out_free;
  logic in_range;

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign in_range = ({1'b0, addr_r} < SRAM_LIM);

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      addr_r      <= '0;
      col_lo_r    <= '0;
      col_hi_r    <= '0;
      pat_r       <= '0;
      speed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      addr_r      <= addr_nxt;
      col_lo_r    <= col_lo_nxt;
      col_hi_r    <= col_hi_nxt;
      pat_r       <= pat_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_fast_r <= out_fast_nxt;
  end

  // Next state, register updates and SRAM requests.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    addr_nxt      = addr_r;
    col_lo_nxt    = col_lo_r;
    col_hi_nxt    = col_hi_r;
    pat_nxt       = pat_r;
    speed_nxt     = speed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_fast_nxt  = out_fast_r;
    mem_req       = '0;

    unique case (state_r)
      ST_CLEAR: begin
        // Fill the SRAM with its reset byte, one entry per cycle.
        mem_req.wr_en = 1'b1;
        mem_req.addr  = ADDR_W'(clr_cnt_r);
        mem_req.wdata = SRAM_RESET;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = IDLE_BYTE;
          if (in_req_type == REQ_WRITE) begin
            unique case (in_port_sel)
              PORT_SWITCH:  speed_nxt = in_write_data[0];
              PORT_COLOR: begin
                col_hi_nxt = in_write_data[7:4];
                col_lo_nxt = in_write_data[3:0];
              end
              PORT_PATTERN: pat_nxt = in_write_data;
              PORT_ADDR_LO: addr_nxt = {addr_r[ADDR_W-1:8], in_write_data};
              PORT_ADDR_HI: addr_nxt = {in_write_data[ADDR_W-9:0], addr_r[7:0]};
              PORT_SRAM: begin
                mem_req.wr_en = in_range;
                mem_req.addr  = addr_r;
                mem_req.wdata = in_write_data;
                addr_nxt      = addr_r + 1'b1;
              end
              default: ;
            endcase
          end else begin
            unique case (in_port_sel)
              PORT_ID:     out_data_nxt = ID_VALUE;
              PORT_SWITCH: out_data_nxt = in_front_switch ? SWITCH_ON : IDLE_BYTE;
              PORT_COLOR: begin
                // Top two pattern bits pick each nibble, then the pattern rotates.
                out_data_nxt = {pat_r[7] ? col_hi_r : col_lo_r,
                                pat_r[6] ? col_hi_r : col_lo_r};
                pat_nxt      = {pat_r[5:0], pat_r[7:6]};
              end
              PORT_SRAM: begin
                // In-range reads go through ST_READ to pick up the registered SRAM data.
                if (in_range) begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = addr_r;
                  out_valid_nxt = 1'b0;
                  state_nxt     = ST_READ;
                end
                addr_nxt = addr_r + 1'b1;
              end
              default: ;
            endcase
          end
          out_fast_nxt = speed_nxt;
        end
      end
      ST_READ: begin
        // Output register is empty here; load the SRAM byte.
        out_valid_nxt = 1'b1;
        out_data_nxt  = mem_rdata;
        out_fast_nxt  = speed_r;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_fast_cpu  = out_fast_r;

endmodule

[rtl/switched_io_sram_pattern_device.sv]
// I/O-mapped peripheral with sixteen sub-ports: ID, front switch, fast-CPU
// flag, a rotating two-color pattern and a byte SRAM of SRAM_BYTES entries
// with an auto-incrementing 13-bit address. Each transaction yields one result
// transaction. For most accesses the result is registered at the edge that
// takes the access. An in-range SRAM read first goes through the registered
// SRAM read port and the ST_READ state. A new access is taken when the
// controller is idle and the result register is empty or is being taken in
// the same cycle. After reset the block runs a clearing pass that writes 0xFF
// into every SRAM byte; in_stall stays high throughout.
module switched_io_sram_pattern_device #(
  parameter int SRAM_BYTES = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [3:0] in_port_sel,
  input  logic [7:0] in_write_data,
  input  logic       in_front_switch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_fast_cpu
);
  import sipd_pkg::*;

  sipd_mem_req_t mem_req;
  logic [7:0]    mem_rdata;

  // Access decode, registers and result register.
  sipd_ctrl #(
    .SRAM_BYTES(SRAM_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_port_sel    (in_port_sel),
    .in_write_data  (in_write_data),
    .in_front_switch(in_front_switch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_fast_cpu   (out_fast_cpu),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  // Byte storage.
  sipd_sram #(
    .SRAM_BYTES(SRAM_BYTES)
  ) u_sram (
    .clk      (clk),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata)
  );

endmodule

[rtl/sipd_checker.sv]
// Port-level checker for the I/O pattern device and its bind statement.
// Depends on switched_io_sram_pattern_device_macros.svh and sipd_pkg.
`include "switched_io_sram_pattern_device_macros.svh"

module sipd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_req_type,
  input logic [3:0] in_port_sel,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_fast_cpu
);
  import sipd_pkg::*;

  logic in_xact;
  logic wr_xact;
  logic id_xact;

  assign in_xact = in_valid && !in_stall;
  assign wr_xact = in_xact && (in_req_type == REQ_WRITE);
  assign id_xact = in_xact && (in_req_type == REQ_READ) && (in_port_sel == PORT_ID);

  // A stalled result transaction keeps its payload.
  `SIPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_read_data) && $stable(out_fast_cpu),
    "stalled result changed")

  // Reset empties the result register and starts the clearing pass.
  `SIPD_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, in_stall && !out_valid,
    "block not stalled and empty after reset")

  // A write transaction returns 0xFF on the next cycle.
  `SIPD_ASSERT_NEXT(a_write_result, clk, rst_n, wr_xact,
    out_valid && (out_read_data == IDLE_BYTE), "write result wrong or late")

  // An ID read returns the ID byte on the next cycle.
  `SIPD_ASSERT_NEXT(a_id_result, clk, rst_n, id_xact,
    out_valid && (out_read_data == ID_VALUE), "ID read wrong or late")

endmodule

bind switched_io_sram_pattern_device sipd_checker u_sipd_checker (.*);

[bench/switched_io_sram_pattern_device_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the I/O pattern device: a directed table of bus
// transactions, then random access sequences, each checked against a stored or predicted result.
// Depends on sipd_pkg and the switched_io_sram_pattern_device RTL.
module switched_io_sram_pattern_device_tb;
  import sipd_pkg::*;

  localparam int SRAM_DEPTH   = 2048;
  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_GAP      = 5;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;

  // Sub-ports with no meaning, used as targets that must be ignored.
  localparam logic [3:0] PORT_SPARE_LO = 4'd2;
  localparam logic [3:0] PORT_SPARE_HI = 4'd15;

  localparam logic [ADDR_W-1:0] ADDR_TOP = 13'h1FFF;

  // Whether a table row carries its own expected result.
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic       req;
    logic [3:0] port;
    logic [7:0] data;
    logic       sw;
  } access_t;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       fast;
  } io_result_t;

  typedef struct packed {
    access_t    acc;
    logic       typed;
    io_result_t res;
  } table_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_req_type;
  logic [3:0] in_port_sel;
  logic [7:0] in_write_data;
  logic       in_front_switch;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_data;
  logic       out_fast_cpu;

  // Shadow copy of the device state.
  logic [7:0]        shadow_sram [SRAM_DEPTH];
  logic [ADDR_W-1:0] shadow_addr;
  logic [3:0]        shadow_col_lo;
  logic [3:0]        shadow_col_hi;
  logic [7:0]        shadow_pattern;
  logic              shadow_speed;

  io_result_t due_results[$];
  table_row_t io_table[$];
  int         error_count = 0;
  int         useful_sent = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;

  switched_io_sram_pattern_device #(
    .SRAM_BYTES(SRAM_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_port_sel(in_port_sel),
    .in_write_data(in_write_data),
    .in_front_switch(in_front_switch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_data(out_read_data),
    .out_fast_cpu(out_fast_cpu)
  );

  always #HALF_PERIOD clk = ~clk;

  // Applies one bus access to the shadow state and returns what it reads.
  function automatic io_result_t apply_io_access(input access_t acc);
    io_result_t res;
    logic [3:0] hi_nib;
    logic [3:0] lo_nib;
    res.rd_byte = IDLE_BYTE;
    if (acc.req == REQ_WRITE) begin
      case (acc.port)
        PORT_SWITCH: shadow_speed = acc.data[0];
        PORT_COLOR: begin
          shadow_col_hi = acc.data[7:4];
          shadow_col_lo = acc.data[3:0];
        end
        PORT_PATTERN: shadow_pattern = acc.data;
        PORT_ADDR_LO: shadow_addr[7:0] = acc.data;
        PORT_ADDR_HI: shadow_addr[12:8] = acc.data[4:0];
        PORT_SRAM: begin
          // Writes beyond the SRAM are dropped; the address still moves on.
          if (shadow_addr < SRAM_DEPTH) shadow_sram[shadow_addr] = acc.data;
          shadow_addr = shadow_addr + 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (acc.port)
        PORT_ID: res.rd_byte = ID_VALUE;
        PORT_SWITCH: res.rd_byte = acc.sw ? SWITCH_ON : IDLE_BYTE;
        PORT_COLOR: begin
          // The top two pattern bits pick the colors, then the pattern rotates.
          hi_nib = shadow_pattern[7] ? shadow_col_hi : shadow_col_lo;
          lo_nib = shadow_pattern[6] ? shadow_col_hi : shadow_col_lo;
          res.rd_byte = {hi_nib, lo_nib};
          shadow_pattern = {shadow_pattern[5:0], shadow_pattern[7:6]};
        end
        PORT_SRAM: begin
          if (shadow_addr < SRAM_DEPTH) res.rd_byte = shadow_sram[shadow_addr];
          shadow_addr = shadow_addr + 1'b1;
        end
        default: ;
      endcase
    end
    res.fast = shadow_speed;
    return res;
  endfunction

  task automatic add_row(input logic req, input logic [3:0] port, input logic [7:0] data,
                         input logic sw, input logic typed, input logic [7:0] rd_byte,
                         input logic fast);
    table_row_t row;
    row.acc   = '{req: req, port: port, data: data, sw: sw};
    row.typed = typed;
    row.res   = '{rd_byte: rd_byte, fast: fast};
    io_table.push_back(row);
  endtask

  // Offers one transaction, after a random gap unless tx_calm is set, and records its expected result.
  task automatic drive_access(input access_t acc, input logic typed,
                              input io_result_t typed_res);
    io_result_t res;
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= acc.req;
    in_port_sel     <= acc.port;
    in_write_data   <= acc.data;
    in_front_switch <= acc.sw;
    do @(posedge clk); while (in_stall);
    res = apply_io_access(acc);
    due_results.push_back(typed ? typed_res : res);
  endtask

  task automatic issue(input logic req, input logic [3:0] port, input logic [7:0] data);
    access_t acc;
    acc = '{req: req, port: port, data: data, sw: 1'($urandom_range(0, 1))};
    if (port inside {PORT_ID, PORT_SWITCH, PORT_COLOR, PORT_PATTERN, PORT_ADDR_LO,
                     PORT_ADDR_HI, PORT_SRAM}) begin
      useful_sent++;
    end
    drive_access(acc, PREDICTED, '0);
  endtask

  // Loads the access address; the unused top bits of the high byte are random.
  task automatic set_address(input logic [ADDR_W-1:0] addr);
    issue(REQ_WRITE, PORT_ADDR_LO, addr[7:0]);
    issue(REQ_WRITE, PORT_ADDR_HI, {3'($urandom), addr[12:8]});
  endtask

  // Stimulus: directed table, then random access sequences.
  initial begin : stimulus
    logic [ADDR_W-1:0] base;
    int scenario;
    int pick;
    int burst;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_READ;
    in_port_sel     <= PORT_ID;
    in_write_data   <= 8'h00;
    in_front_switch <= 1'b0;

    foreach (shadow_sram[i]) shadow_sram[i] = SRAM_RESET;
    shadow_addr    = '0;
    shadow_col_lo  = '0;
    shadow_col_hi  = '0;
    shadow_pattern = '0;
    shadow_speed   = 1'b0;

    // Fixed reads and the fast-CPU flag after reset.
    add_row(REQ_READ,  PORT_ID,       8'h00, 1'b0, TYPED, ID_VALUE,  1'b0);
    add_row(REQ_READ,  PORT_SWITCH,   8'h00, 1'b1, TYPED, SWITCH_ON, 1'b0);
    add_row(REQ_READ,  PORT_SWITCH,   8'hFF, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_SWITCH,   8'hFF, 1'b0, TYPED, IDLE_BYTE, 1'b1);
    add_row(REQ_WRITE, PORT_SWITCH,   8'hFE, 1'b1, TYPED, IDLE_BYTE, 1'b0);
    // SRAM after reset, the top address, a dropped write and the wrap to zero.
    add_row(REQ_READ,  PORT_SRAM,     8'h00, 1'b0, TYPED, SRAM_RESET, 1'b0);
    add_row(REQ_WRITE, PORT_ADDR_LO,  8'hFF, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_ADDR_HI,  8'hFF, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_SRAM,     8'h00, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_SRAM,     8'hA5, 1'b1, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_ADDR_LO,  8'h00, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_READ,  PORT_SRAM,     8'hFF, 1'b0, PREDICTED, 8'h00, 1'b0);
    // Read beyond the SRAM, then the last in-range byte.
    add_row(REQ_WRITE, PORT_ADDR_HI,  8'h08, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_READ,  PORT_SRAM,     8'h00, 1'b1, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_ADDR_HI,  8'h07, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_ADDR_LO,  8'hFF, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_SRAM,     8'h5A, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_ADDR_LO,  8'hFF, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_ADDR_HI,  8'hE7, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_READ,  PORT_SRAM,     8'h00, 1'b0, PREDICTED, 8'h00, 1'b0);
    // Colors and the rotating pattern.
    add_row(REQ_WRITE, PORT_COLOR,    8'h3C, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_PATTERN,  8'h9C, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_READ,  PORT_COLOR,    8'h00, 1'b0, PREDICTED, 8'h00, 1'b0);
    add_row(REQ_READ,  PORT_COLOR,    8'hFF, 1'b1, PREDICTED, 8'h00, 1'b0);
    // Ports with no meaning, including a write to the ID port.
    add_row(REQ_WRITE, PORT_SPARE_HI, 8'hFF, 1'b1, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_READ,  PORT_SPARE_LO, 8'h00, 1'b0, TYPED, IDLE_BYTE, 1'b0);
    add_row(REQ_WRITE, PORT_ID,       8'h00, 1'b0, TYPED, IDLE_BYTE, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (io_table[i]) drive_access(io_table[i].acc, io_table[i].typed, io_table[i].res);

    // Random part: mostly well-formed access sequences with random content.
    while (useful_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
      scenario = $urandom_range(0, 9);
      case (scenario)
        0, 1, 2, 3: begin
          // SRAM burst: write a run of bytes, then read up to that many, mostly from the base again.
          pick = $urandom_range(0, 9);
          if (pick < 7) base = 13'($urandom_range(0, SRAM_DEPTH - 1));
          else if (pick < 9) base = 13'(SRAM_DEPTH - 4 + $urandom_range(0, 7));
          else base = ADDR_TOP - 13'($urandom_range(0, 6));
          burst = $urandom_range(1, 8);
          set_address(base);
          repeat (burst) issue(REQ_WRITE, PORT_SRAM, 8'($urandom));
          if ($urandom_range(0, 3) != 0) set_address(base);
          repeat ($urandom_range(1, burst)) issue(REQ_READ, PORT_SRAM, 8'($urandom));
        end
        4: begin
          if ($urandom_range(0, 1) == 1) issue(REQ_WRITE, PORT_COLOR, 8'($urandom));
          issue(REQ_WRITE, PORT_PATTERN, 8'($urandom));
          repeat ($urandom_range(1, 5)) issue(REQ_READ, PORT_COLOR, 8'($urandom));
        end
        5: begin
          issue(REQ_WRITE, PORT_COLOR, 8'($urandom));
          issue(REQ_READ, PORT_COLOR, 8'($urandom));
        end
        6: begin
          issue(REQ_READ, PORT_SWITCH, 8'($urandom));
          issue(REQ_WRITE, PORT_SWITCH, 8'($urandom));
        end
        7: issue(REQ_READ, PORT_ID, 8'($urandom));
        default: begin
          // Noise: any access to any port.
          issue(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 8'($urandom));
        end
      endcase
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("switched_io_sram_pattern_device verification clean");
    end else begin
      $display("switched_io_sram_pattern_device verification failed");
    end
    $finish;
  end

  // Result side stall: random holds per transaction, one long hold-off.
  initial begin : result_stall
    int hold;
    int rx_count;
    bit hold_done;
    rx_count  = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_count == HOLD_AT && !hold_done) begin
        hold      = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        hold = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      rx_count++;
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin : result_check
    io_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result read_data=%02h fast_cpu=%0b",
                 $time, out_read_data, out_fast_cpu);
        error_count++;
      end else begin
        want = due_results.pop_front();
        if (out_read_data !== want.rd_byte) begin
          $display("%0t: read_data expected %02h actual %02h",
                   $time, want.rd_byte, out_read_data);
          error_count++;
        end
        if (out_fast_cpu !== want.fast) begin
          $display("%0t: fast_cpu expected %0b actual %0b",
                   $time, want.fast, out_fast_cpu);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
    $display("switched_io_sram_pattern_device verification failed");
    $finish;
  end

endmodule
